@@ hw/rtl/tptu_pkg.sv @@
`timescale 1ns / 1ps

package tptu_pkg;

  localparam int TABLE_SLOTS_DEF = 8;
  localparam int ADDR_W          = 48;

  // action codes
  localparam logic [2:0] ACT_BEGIN  = 3'd0;
  localparam logic [2:0] ACT_TAP    = 3'd1;
  localparam logic [2:0] ACT_EXTEND = 3'd2;
  localparam logic [2:0] ACT_UNDO   = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // tap outcome codes
  localparam logic [1:0] TAP_IGNORED = 2'd0;
  localparam logic [1:0] TAP_PENDING = 2'd1;
  localparam logic [1:0] TAP_BOUND   = 2'd2;

  typedef struct packed {
    logic [2:0]        action;
    logic [ADDR_W-1:0] node_address;
    logic [7:0]        requested_positions;
    logic [7:0]        slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        tap_result;
    logic              accepted;
    logic [ADDR_W-1:0] slot_address;
    logic signed [3:0] next_prompt;
    logic [3:0]        bound_count;
    logic [3:0]        target_count;
  } rsp_t;

endpackage

@@ hw/rtl/tptu_slot_mem.sv @@
`timescale 1ns / 1ps

module tptu_slot_mem import tptu_pkg::*; #(
  parameter int DEPTH = TABLE_SLOTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [ADDR_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [ADDR_W-1:0] rdata
);

  // no reset: only entries below the bound count are ever used
  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/two_tap_pairing_table_unit.sv @@
`timescale 1ns / 1ps

// Steps: begin, extend, undo and unused codes pass APPLY and RESP into the result register;
//   read passes FETCH first; tap first scans each bound entry in SCAN.
// Flow: a new request is taken only back in IDLE, once the last result is loaded; the slot
//   scan reads one table entry per cycle through the single read port and one shared 48-bit comparator.
// Reset (rst, synchronous): round idle, counts and pending candidate cleared, no result
//   held. Table contents are not cleared; entries at or above the bound count are never used.
module two_tap_pairing_table_unit import tptu_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int CW = $clog2(TABLE_SLOTS + 1);              // holds 0..TABLE_SLOTS
  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [7:0]    SLOTS8   = 8'(TABLE_SLOTS);
  localparam logic [CW-1:0] SLOTS_CW = CW'(TABLE_SLOTS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_APPLY = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t state, state_next;

  // round state
  logic [CW-1:0]     bound, bound_next;
  logic [CW-1:0]     target, target_next;
  logic [ADDR_W-1:0] pending_address, pending_address_next;
  logic              pending_valid, pending_valid_next;

  // request in flight
  req_t    item;
  logic    hit;                 // tapping address already bound
  logic [CW-1:0] scan_idx;      // next entry to read
  logic    cmp_valid;           // rdata holds an entry to compare this cycle
  rsp_t    res, res_next;

  // table port
  logic              mem_we;
  logic [AW-1:0]     mem_raddr;
  logic [ADDR_W-1:0] mem_rdata;

  // shared comparator: table entry during the scan, pending candidate otherwise
  logic [ADDR_W-1:0] cmp_b;
  logic              eq;

  logic       active, active_next;
  logic [7:0] n_req;

  assign req_stall = (state != ST_IDLE);

  assign cmp_b = (state == ST_SCAN) ? mem_rdata : pending_address;
  assign eq    = (item.node_address == cmp_b);

  always_comb begin
    unique case (state)
      ST_SCAN:  mem_raddr = scan_idx[AW-1:0];
      ST_FETCH: mem_raddr = item.slot_index[AW-1:0];
      default:  mem_raddr = '0;
    endcase
  end

  tptu_slot_mem #(
    .DEPTH (TABLE_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (bound[AW-1:0]),
    .wdata (item.node_address),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // --- action decode, evaluated in APPLY ---
  always_comb begin
    bound_next           = bound;
    target_next          = target;
    pending_address_next = pending_address;
    pending_valid_next   = pending_valid;
    mem_we               = 1'b0;
    res_next             = '0;
    res_next.tap_result  = TAP_IGNORED;

    // request clamped to the table size
    n_req  = (item.requested_positions > SLOTS8) ? SLOTS8 : item.requested_positions;
    active = (target != '0) && (bound < target);

    unique case (item.action)
      ACT_BEGIN: begin
        bound_next         = '0;
        target_next        = (n_req == 8'd0) ? CW'(1) : CW'(n_req);
        pending_valid_next = 1'b0;
        res_next.accepted  = 1'b1;
      end
      ACT_TAP: begin
        if (active && !hit) begin
          if (!pending_valid || !eq) begin
            // new candidate
            pending_address_next = item.node_address;
            pending_valid_next   = 1'b1;
            res_next.tap_result  = TAP_PENDING;
          end else if (bound < SLOTS_CW) begin
            // second tap in a row: bind to the next slot
            mem_we              = (state == ST_APPLY);
            bound_next          = bound + CW'(1);
            pending_valid_next  = 1'b0;
            res_next.tap_result = TAP_BOUND;
          end
        end
      end
      ACT_EXTEND: begin
        if ((target != '0) && (n_req > 8'(target))) begin
          target_next        = CW'(n_req);
          pending_valid_next = 1'b0;
          res_next.accepted  = 1'b1;
        end
      end
      ACT_UNDO: begin
        if (bound != '0) begin
          bound_next = bound - CW'(1);
        end
        pending_valid_next = 1'b0;
      end
      ACT_READ: begin
        if (item.slot_index < 8'(bound)) begin
          res_next.accepted     = 1'b1;
          res_next.slot_address = mem_rdata;
        end
      end
      default: begin
        // unused codes: status only
      end
    endcase

    active_next           = (target_next != '0) && (bound_next < target_next);
    res_next.next_prompt  = active_next ? signed'(4'(bound_next)) : -4'sd1;
    res_next.bound_count  = 4'(bound_next);
    res_next.target_count = 4'(target_next);
  end

  // --- sequencer ---
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.action == ACT_TAP) begin
            state_next = ST_SCAN;
          end else if (req.action == ACT_READ) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_APPLY;
          end
        end
      end
      ST_SCAN: begin
        // done once every bound entry has been issued and compared
        if ((scan_idx == bound) && !cmp_valid) begin
          state_next = ST_APPLY;
        end
      end
      ST_FETCH: state_next = ST_APPLY;
      ST_APPLY: state_next = ST_RESP;
      ST_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      bound         <= '0;
      target        <= '0;
      pending_valid <= 1'b0;
      rsp_valid     <= 1'b0;
      cmp_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_APPLY) begin
        bound         <= bound_next;
        target        <= target_next;
        pending_valid <= pending_valid_next;
      end

      if (state == ST_SCAN) begin
        cmp_valid <= (scan_idx < bound);
      end else begin
        cmp_valid <= 1'b0;
      end

      // output register: loaded from RESP, freed by the downstream transfer
      if ((state == ST_RESP) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && req_valid) begin
      item     <= req;
      hit      <= 1'b0;
      scan_idx <= '0;
    end
    if (state == ST_SCAN) begin
      if (cmp_valid && eq) begin
        hit <= 1'b1;
      end
      if (scan_idx < bound) begin
        scan_idx <= scan_idx + CW'(1);
      end
    end
    if (state == ST_APPLY) begin
      res             <= res_next;
      pending_address <= pending_address_next;
    end
    if ((state == ST_RESP) && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
  end

  // --- checks ---
  a_bound_in_target: assert property (@(posedge clk) disable iff (rst)
    bound <= target)
    else $error("bound count above target");

  a_bound_in_table: assert property (@(posedge clk) disable iff (rst)
    bound <= SLOTS_CW)
    else $error("bound count above table size");

  a_pending_needs_round: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> (target != '0))
    else $error("pending candidate while idle");

  a_rsp_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_RESP))
    else $error("result raised outside response state");

endmodule

@@ test/tb_two_tap_pairing_table_unit.sv @@
`timescale 1ns / 1ps

module tb_two_tap_pairing_table_unit;
  import tptu_pkg::*;

  localparam int SLOTS         = TABLE_SLOTS_DEF;
  localparam int QUIET_LIMIT   = 3000;  // cycles with no transfer on either side
  localparam int SETTLE_CYCLES = 20;    // idle time before the final verdict
  localparam int LONG_HOLD     = 300;   // receiver hold-off to back the block up
  localparam int PHASE_ITEMS   = 280;

  // action codes the block does not define; it must leave its state alone
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [ADDR_W-1:0] ADDR_ZERO = '0;
  localparam logic [ADDR_W-1:0] ADDR_MIX  = 48'hC3A5_0F96_7E18;

  // ---------------------------------------------------------------------------
  // Scoreboard: keeps a private copy of the pairing table, works out the status
  // each accepted request should produce, and checks results in order.
  // ---------------------------------------------------------------------------
  class pairing_scoreboard;
    logic [ADDR_W-1:0] slot_map [SLOTS];
    int unsigned       n_bound;
    int unsigned       n_target;
    logic [ADDR_W-1:0] cand_addr;
    bit                cand_valid;
    rsp_t              expected_q [$];
    int                failures;

    function new();
      foreach (slot_map[i]) slot_map[i] = '0;
      n_bound    = 0;
      n_target   = 0;
      cand_addr  = '0;
      cand_valid = 1'b0;
      failures   = 0;
    endfunction

    // round is open while a target is set and not yet met
    function bit round_open();
      return n_target > 0 && n_bound < n_target;
    endfunction

    function bit already_bound(logic [ADDR_W-1:0] a);
      for (int i = 0; i < n_bound; i++)
        if (slot_map[i] == a) return 1'b1;
      return 1'b0;
    endfunction

    function int unsigned clamp_target(logic [7:0] want);
      return (want > SLOTS) ? SLOTS : int'(want);
    endfunction

    // applies one request to the table copy and returns the status it yields
    function rsp_t apply_action(req_t r);
      rsp_t        e;
      int unsigned n;
      e = '0;
      e.tap_result = TAP_IGNORED;
      case (r.action)
        ACT_BEGIN: begin
          n = clamp_target(r.requested_positions);
          if (n < 1) n = 1;
          foreach (slot_map[i]) slot_map[i] = '0;
          n_bound    = 0;
          n_target   = n;
          cand_valid = 1'b0;
          e.accepted = 1'b1;
        end
        ACT_TAP: begin
          if (round_open() && !already_bound(r.node_address)) begin
            if (!cand_valid || cand_addr != r.node_address) begin
              cand_addr    = r.node_address;
              cand_valid   = 1'b1;
              e.tap_result = TAP_PENDING;
            end else if (n_bound < SLOTS) begin
              slot_map[n_bound] = r.node_address;
              n_bound++;
              cand_valid   = 1'b0;
              e.tap_result = TAP_BOUND;
            end
          end
        end
        ACT_EXTEND: begin
          n = clamp_target(r.requested_positions);
          if (n_target != 0 && n > n_target) begin
            n_target   = n;
            cand_valid = 1'b0;
            e.accepted = 1'b1;
          end
        end
        ACT_UNDO: begin
          if (n_bound > 0) begin
            n_bound--;
            slot_map[n_bound] = '0;
          end
          cand_valid = 1'b0;
        end
        ACT_READ: begin
          if (r.slot_index < n_bound) begin
            e.slot_address = slot_map[r.slot_index];
            e.accepted     = 1'b1;
          end
        end
        default: ;
      endcase
      e.next_prompt  = round_open() ? 4'(n_bound) : -4'sd1;
      e.bound_count  = 4'(n_bound);
      e.target_count = 4'(n_target);
      return e;
    endfunction

    function void note_request(req_t r);
      expected_q.push_back(apply_action(r));
    endfunction

    function void compare_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("tap_result", want.tap_result, got.tap_result);
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("slot_address", want.slot_address, got.slot_address);
      compare_field("next_prompt", $unsigned(want.next_prompt), $unsigned(got.next_prompt));
      compare_field("bound_count", want.bound_count, got.bound_count);
      compare_field("target_count", want.target_count, got.target_count);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals; every input of the block starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  pairing_scoreboard sb = new();

  int                send_idle_pct  = 0;
  int                rsp_stall_pct  = 0;
  int                long_hold_left = 0;
  int                items_sent     = 0;
  int                quiet_cycles   = 0;
  logic [ADDR_W-1:0] addr_pool [8];
  int                pool_next      = 0;

  two_tap_pairing_table_unit #(.TABLE_SLOTS(SLOTS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: random stall at the phase's rate; a long hold-off, once asked
  // for, is counted down here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (long_hold_left > 0) begin
      rsp_stall <= 1'b1;
      long_hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  // Result monitor: values read here are those from before the edge.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // Watchdog: ends the run once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [ADDR_W-1:0] a;
    a[ADDR_W-1:32] = 16'($urandom);
    a[31:0]        = $urandom;
    return a;
  endfunction

  // mostly small requests, now and then the full byte range
  function automatic logic [7:0] pick_count();
    return ($urandom_range(99) < 85) ? 8'($urandom_range(10, 0)) : 8'($urandom);
  endfunction

  function automatic req_t make_req(logic [2:0] act, logic [ADDR_W-1:0] addr,
                                    logic [7:0] want, logic [7:0] idx);
    req_t r;
    r.action              = act;
    r.node_address        = addr;
    r.requested_positions = want;
    r.slot_index          = idx;
    return r;
  endfunction

  // tap address: reuse of earlier addresses gives taps from bound nodes
  function automatic logic [ADDR_W-1:0] pick_addr();
    int                p;
    logic [ADDR_W-1:0] a;
    p = $urandom_range(99);
    if (p < 25) return addr_pool[$urandom_range(7)];
    if (p < 28) return ADDR_ONES;
    if (p < 31) return ADDR_ZERO;
    a = rand_addr();
    addr_pool[pool_next] = a;
    pool_next = (pool_next + 1) % 8;
    return a;
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid stays
  // high afterwards, so a back-to-back request only reloads the payload.
  task automatic send_request(input req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic tap(input logic [ADDR_W-1:0] a);
    send_request(make_req(ACT_TAP, a, 8'($urandom), 8'($urandom)));
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // One random step. Mostly well-formed tap pairs so rounds actually fill;
  // the rest is reads, extends, undos, lone taps, spare codes and new rounds.
  task automatic random_step();
    int                p;
    logic [ADDR_W-1:0] a;
    p = $urandom_range(99);
    if (p < 55) begin
      a = pick_addr();
      tap(a);
      if ($urandom_range(9) == 0) tap(pick_addr());  // broken pair
      tap(a);
    end else if (p < 62) begin
      tap(pick_addr());
    end else if (p < 72) begin
      send_request(make_req(ACT_READ, rand_addr(), 8'($urandom),
                            ($urandom_range(99) < 85) ? 8'($urandom_range(9, 0))
                                                      : 8'($urandom)));
    end else if (p < 80) begin
      send_request(make_req(ACT_EXTEND, rand_addr(), pick_count(), 8'($urandom)));
    end else if (p < 87) begin
      send_request(make_req(ACT_UNDO, rand_addr(), 8'($urandom), 8'($urandom)));
    end else if (p < 91) begin
      send_request(make_req(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)), rand_addr(),
                            8'($urandom), 8'($urandom)));
    end else begin
      send_request(make_req(ACT_BEGIN, rand_addr(), pick_count(), 8'($urandom)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase_start;
    bit hold_done;

    foreach (addr_pool[i]) addr_pool[i] = rand_addr();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: idle round first
    send_request(make_req(ACT_READ, ADDR_MIX, 8'd0, 8'd0));       // nothing bound yet
    tap(ADDR_ONES);                                               // ignored while idle
    send_request(make_req(ACT_EXTEND, ADDR_ZERO, 8'd5, 8'd0));    // refused while idle
    send_request(make_req(ACT_UNDO, ADDR_ZERO, 8'd0, 8'd0));      // nothing to unbind
    // zero request still gives a one-slot round
    send_request(make_req(ACT_BEGIN, ADDR_ZERO, 8'd0, 8'hFF));
    tap(ADDR_ONES);
    tap(ADDR_ONES);                                               // bound, round complete
    tap(ADDR_MIX);                                                // ignored once complete
    send_request(make_req(ACT_READ, ADDR_ZERO, 8'd0, 8'd0));
    send_request(make_req(ACT_UNDO, ADDR_ONES, 8'hFF, 8'hFF));    // reopens the round
    tap(ADDR_ONES);
    tap(ADDR_ONES);
    send_request(make_req(ACT_EXTEND, ADDR_ZERO, 8'hFF, 8'd0));   // saturates at table size
    send_request(make_req(ACT_EXTEND, ADDR_ZERO, 8'd2, 8'd0));    // lower target refused
    tap(ADDR_ONES);                                               // already bound
    tap(ADDR_ZERO);
    tap(ADDR_MIX);                                                // replaces the candidate
    tap(ADDR_MIX);
    tap(ADDR_ZERO);
    tap(ADDR_ONES);                                               // bound node, candidate kept
    tap(ADDR_ZERO);
    send_request(make_req(ACT_READ, ADDR_ONES, 8'd0, 8'd2));
    send_request(make_req(ACT_READ, ADDR_ONES, 8'd0, 8'hFF));
    send_request(make_req(ACT_READ, ADDR_ONES, 8'd0, 8'd3));
    send_request(make_req(ACT_SPARE_LO, ADDR_ONES, 8'hFF, 8'hFF));
    send_request(make_req(ACT_SPARE_LO + 3'd1, ADDR_MIX, 8'd3, 8'd1));
    send_request(make_req(ACT_SPARE_HI, ADDR_ZERO, 8'd0, 8'd0));
    send_request(make_req(ACT_BEGIN, ADDR_MIX, 8'd200, 8'd0));    // saturates at table size
    drain_results();

    // random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 83 : (ph == 3) ? 33 : 0;
      rsp_stall_pct = (ph == 2) ? 83 : (ph == 3) ? 33 : 0;
      phase_start   = items_sent;
      hold_done     = 1'b0;
      while (items_sent < phase_start + PHASE_ITEMS) begin
        // long receiver hold-off mid-phase while requests keep coming
        if (ph == 0 && !hold_done && items_sent > phase_start + 100) begin
          long_hold_left = LONG_HOLD;
          hold_done      = 1'b1;
        end
        random_step();
      end
      // sender pauses until every outstanding result has arrived
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
